// ----- hdl/has_pkg.sv -----
package has_pkg;

  localparam int unsigned MaxSize = 16;

  localparam int unsigned CostW = 48;
  localparam logic [CostW-1:0] CostTop = {CostW{1'b1}};

  localparam logic [0:0] RegMatrixSize = 1'b0;
  localparam logic [0:0] RegMaxRounds  = 1'b1;

  typedef enum logic [4:0] {
    StIdle,
    StRowMinRd,
    StRowMinAcc,
    StRowSubRd,
    StRowSubWr,
    StColSubRd,
    StColSubWr,
    StGreedyRd,
    StGreedyChk,
    StSweepNext,
    StAugInit,
    StAugRd,
    StAugChk,
    StAugWrite,
    StLowRd,
    StLowAcc,
    StAdjRd,
    StAdjWr,
    StRoundEnd,
    StEmit
  } state_e;

endpackage

// ----- hdl/has_ram.sv -----
module has_ram #(
  parameter int unsigned Width = 48,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- hdl/hungarian_assignment_solver.sv -----
// Minimum-cost assignment solver (Hungarian method on a DFS augmenting search).
//
// Channels:
//   Input: start with cost_i is one transaction, accepted when start is high
//   and busy is low. Elements arrive in row-major order; the element that
//   completes the n-by-n matrix launches the solve.
//   Config: cfg_valid_i/cfg_ready_o with cfg_index_i and cfg_data_i. Ready only
//   while idle with no element offered. Index 0 is matrix_size (discards any
//   partial load), index 1 is max_rounds.
//   Output: result_valid_o strobes once per row, rows 0..n-1 in order, with
//   last_o on row n-1. The receiver cannot stall, so results go out back to
//   back; busy stays high until the last row.
// Loading: elements are accepted back to back while idle. A solve walks the
// matrix in the cost RAM through one read port, a read then a compare/update
// per element per pass, six passes per round plus searches that read then
// check each column tried; the number of rounds is bounded by max_rounds.
// Reset: matrix_size returns to 16, max_rounds to 100, load count clears. The
// cost RAM has no reset; only loaded elements are read.
module hungarian_assignment_solver (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  input  logic [31:0] cost_i,
  output logic        busy,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [0:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  output logic        result_valid_o,
  output logic [3:0]  row_index_o,
  output logic [3:0]  assigned_column_o,
  output logic        failed_o,
  output logic        last_o
);

  localparam int unsigned MaxSize = has_pkg::MaxSize;
  localparam int unsigned IdxW  = $clog2(MaxSize);
  localparam int unsigned AddrW = 2 * IdxW;
  localparam int unsigned CntW  = IdxW + 1;
  localparam int unsigned Cw    = has_pkg::CostW;

  has_pkg::state_e state_q, state_d;

  logic [4:0]  size_q;
  logic [15:0] rounds_cfg_q;
  logic [CntW-1:0] n;

  always_comb begin
    if (size_q == 5'd0) n = CntW'(1);
    else if ({27'd0, size_q} > MaxSize) n = CntW'(MaxSize);
    else n = CntW'(size_q);
  end

  // Load position tracked as row/column.
  logic [IdxW-1:0] ld_r_q, ld_c_q;
  logic            ld_last;
  assign ld_last = ({1'b0, ld_r_q} == n - CntW'(1)) && ({1'b0, ld_c_q} == n - CntW'(1));

  // Scan indices.
  logic [IdxW-1:0] i_q, i_d, j_q, j_d;
  logic [15:0]     round_q, round_d;
  logic [CntW-1:0] matched_q, matched_d;
  logic [Cw-1:0]   acc_q, acc_d;
  logic            progress_q, progress_d;
  logic            ok_q, ok_d;

  logic [IdxW-1:0] row_match_q [MaxSize];
  logic [IdxW-1:0] col_match_q [MaxSize];
  logic [MaxSize-1:0] row_has_q, col_has_q, row_reach_q, col_reach_q;
  logic [Cw-1:0]   colmin_q [MaxSize];
  logic [IdxW-1:0] stk_row_q [MaxSize];
  logic [IdxW-1:0] stk_col_q [MaxSize];
  logic [CntW-1:0] stk_next_q [MaxSize];
  logic [IdxW-1:0] d_q, d_d;
  logic [IdxW-1:0] k_q;

  // RAM
  logic             we;
  logic [AddrW-1:0] waddr, raddr;
  logic [Cw-1:0]    wdata, rdata;

  has_ram #(.Width(Cw), .Depth(MaxSize * MaxSize)) u_cost (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  logic accept;
  logic cfg_we;
  assign accept = start && !busy;
  assign busy = (state_q != has_pkg::StIdle);
  // Hold config off during a solve and while an element is offered.
  assign cfg_ready_o = !busy && !start;
  assign cfg_we = cfg_valid_i && cfg_ready_o;

  logic i_end, j_end;
  assign i_end = ({1'b0, i_q} == n - CntW'(1));
  assign j_end = ({1'b0, j_q} == n - CntW'(1));

  logic [IdxW-1:0] cur_row;
  assign cur_row = stk_row_q[d_q];

  // Shared subtract/saturating add unit.
  logic [Cw-1:0] sub_a, sub_b, sub_y;
  assign sub_y = sub_a - sub_b;
  logic [Cw:0] sat_sum;
  assign sat_sum = {1'b0, rdata} + {1'b0, acc_q};

  logic aug_hit;
  assign aug_hit = (rdata == '0) && !(col_has_q[j_q] && col_match_q[j_q] == cur_row)
                   && !col_reach_q[j_q];

  always_comb begin
    state_d = state_q;
    i_d = i_q; j_d = j_q; round_d = round_q; matched_d = matched_q;
    acc_d = acc_q; progress_d = progress_q; ok_d = ok_q; d_d = d_q;
    case (state_q)
      has_pkg::StIdle: begin
        if (accept && ld_last) begin
          i_d = '0; j_d = '0; round_d = '0; ok_d = 1'b0; matched_d = '0;
          state_d = (rounds_cfg_q == 16'd0) ? has_pkg::StEmit : has_pkg::StRowMinRd;
          acc_d = has_pkg::CostTop;
        end
      end
      has_pkg::StRowMinRd: state_d = has_pkg::StRowMinAcc;
      has_pkg::StRowMinAcc: begin
        if (rdata < acc_q) acc_d = rdata;
        if (j_end) begin
          j_d = '0; state_d = has_pkg::StRowSubRd;
        end else begin
          j_d = j_q + IdxW'(1); state_d = has_pkg::StRowMinRd;
        end
      end
      has_pkg::StRowSubRd: state_d = has_pkg::StRowSubWr;
      has_pkg::StRowSubWr: begin
        if (!j_end) begin
          j_d = j_q + IdxW'(1); state_d = has_pkg::StRowSubRd;
        end else begin
          j_d = '0; acc_d = has_pkg::CostTop;
          if (i_end) begin
            i_d = '0; state_d = has_pkg::StColSubRd;
          end else begin
            i_d = i_q + IdxW'(1); state_d = has_pkg::StRowMinRd;
          end
        end
      end
      has_pkg::StColSubRd: state_d = has_pkg::StColSubWr;
      has_pkg::StColSubWr: begin
        state_d = has_pkg::StColSubRd;
        if (!j_end) j_d = j_q + IdxW'(1);
        else begin
          j_d = '0;
          if (i_end) begin
            i_d = '0; matched_d = '0; state_d = has_pkg::StGreedyRd;
          end else i_d = i_q + IdxW'(1);
        end
      end
      has_pkg::StGreedyRd: state_d = has_pkg::StGreedyChk;
      has_pkg::StGreedyChk: begin
        state_d = has_pkg::StGreedyRd;
        if (rdata == '0 && !col_has_q[j_q]) begin
          matched_d = matched_q + CntW'(1);
          j_d = '0;
          if (i_end) state_d = has_pkg::StSweepNext;
          else i_d = i_q + IdxW'(1);
        end else if (!j_end) j_d = j_q + IdxW'(1);
        else begin
          j_d = '0;
          if (i_end) state_d = has_pkg::StSweepNext;
          else i_d = i_q + IdxW'(1);
        end
        if (state_d == has_pkg::StSweepNext) begin
          i_d = '0; progress_d = 1'b0;
        end
      end
      // Walk rows 0..n-1 for an augmenting search, then repeat while progress.
      has_pkg::StSweepNext: begin
        if (matched_q == n) begin
          i_d = '0; ok_d = 1'b1; state_d = has_pkg::StEmit;
        end else if (!row_has_q[i_q]) begin
          state_d = has_pkg::StAugInit;
        end else if (!i_end) begin
          i_d = i_q + IdxW'(1);
        end else if (progress_q) begin
          i_d = '0; progress_d = 1'b0;
        end else begin
          i_d = '0; j_d = '0; acc_d = has_pkg::CostTop; state_d = has_pkg::StLowRd;
        end
      end
      has_pkg::StAugInit: begin
        d_d = '0; j_d = '0; state_d = has_pkg::StAugRd;
      end
      has_pkg::StAugRd: begin
        if (stk_next_q[d_q] >= n) begin
          // Exhausted this level.
          if (d_q == '0) begin
            state_d = has_pkg::StSweepNext;
            if (!i_end) i_d = i_q + IdxW'(1);
            else if (progress_q) begin
              i_d = '0; progress_d = 1'b0;
            end else begin
              i_d = '0; j_d = '0; acc_d = has_pkg::CostTop; state_d = has_pkg::StLowRd;
            end
          end else d_d = d_q - IdxW'(1);
        end else begin
          j_d = stk_next_q[d_q][IdxW-1:0];
          state_d = has_pkg::StAugChk;
        end
      end
      has_pkg::StAugChk: begin
        state_d = has_pkg::StAugRd;
        if (aug_hit) begin
          if (!col_has_q[j_q]) state_d = has_pkg::StAugWrite;
          else if ({1'b0, d_q} + CntW'(1) < CntW'(MaxSize)) d_d = d_q + IdxW'(1);
        end
      end
      has_pkg::StAugWrite: begin
        if (k_q == d_q) begin
          progress_d = 1'b1;
          matched_d = matched_q + CntW'(1);
          state_d = has_pkg::StSweepNext;
          if (matched_q + CntW'(1) != n) begin
            if (!i_end) i_d = i_q + IdxW'(1);
            else begin
              i_d = '0; progress_d = 1'b0;
            end
          end
        end
      end
      has_pkg::StLowRd: state_d = has_pkg::StLowAcc;
      has_pkg::StLowAcc: begin
        state_d = has_pkg::StLowRd;
        if (row_reach_q[i_q] && !col_reach_q[j_q] && rdata < acc_q) acc_d = rdata;
        if (!j_end) j_d = j_q + IdxW'(1);
        else begin
          j_d = '0;
          if (i_end) begin
            i_d = '0; state_d = has_pkg::StAdjRd;
          end else i_d = i_q + IdxW'(1);
        end
      end
      has_pkg::StAdjRd: state_d = has_pkg::StAdjWr;
      has_pkg::StAdjWr: begin
        state_d = has_pkg::StAdjRd;
        if (!j_end) j_d = j_q + IdxW'(1);
        else begin
          j_d = '0;
          if (i_end) begin
            i_d = '0; state_d = has_pkg::StRoundEnd;
          end else i_d = i_q + IdxW'(1);
        end
      end
      has_pkg::StRoundEnd: begin
        round_d = round_q + 16'd1;
        acc_d = has_pkg::CostTop;
        state_d = (round_q + 16'd1 >= rounds_cfg_q) ? has_pkg::StEmit : has_pkg::StRowMinRd;
      end
      has_pkg::StEmit: begin
        if (i_end) begin
          i_d = '0; state_d = has_pkg::StIdle;
        end else i_d = i_q + IdxW'(1);
      end
      default: state_d = has_pkg::StIdle;
    endcase
  end

  // RAM port and arithmetic unit steering.
  always_comb begin
    we = 1'b0;
    waddr = {i_q, j_q};
    raddr = {i_q, j_q};
    wdata = rdata;
    sub_a = rdata;
    sub_b = acc_q;
    case (state_q)
      has_pkg::StIdle: begin
        we = accept;
        waddr = {ld_r_q, ld_c_q};
        wdata = {{(Cw-32){1'b0}}, cost_i};
      end
      has_pkg::StRowSubWr: begin
        we = 1'b1; wdata = sub_y;
      end
      has_pkg::StColSubWr: begin
        we = 1'b1; sub_b = colmin_q[j_q]; wdata = sub_y;
      end
      has_pkg::StAugRd: raddr = {cur_row, stk_next_q[d_q][IdxW-1:0]};
      has_pkg::StAugChk: raddr = {cur_row, j_q};
      has_pkg::StAdjWr: begin
        if (row_reach_q[i_q] && !col_reach_q[j_q]) begin
          we = 1'b1; wdata = sub_y;
        end else if (!row_reach_q[i_q] && col_reach_q[j_q]) begin
          we = 1'b1;
          wdata = sat_sum[Cw] ? has_pkg::CostTop : sat_sum[Cw-1:0];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= has_pkg::StIdle;
      size_q <= 5'd16;
      rounds_cfg_q <= 16'd100;
      ld_r_q <= '0;
      ld_c_q <= '0;
      i_q <= '0;
      j_q <= '0;
      round_q <= '0;
      matched_q <= '0;
      progress_q <= 1'b0;
      ok_q <= 1'b0;
      d_q <= '0;
      k_q <= '0;
      row_has_q <= '0;
      col_has_q <= '0;
      row_reach_q <= '0;
      col_reach_q <= '0;
    end else begin
      state_q <= state_d;
      i_q <= i_d; j_q <= j_d; round_q <= round_d; matched_q <= matched_d;
      progress_q <= progress_d; ok_q <= ok_d; d_q <= d_d;
      if (cfg_we) begin
        case (cfg_index_i)
          has_pkg::RegMatrixSize: begin
            size_q <= cfg_data_i[4:0]; ld_r_q <= '0; ld_c_q <= '0;
          end
          has_pkg::RegMaxRounds: rounds_cfg_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (accept) begin
        if (ld_last) begin
          ld_r_q <= '0; ld_c_q <= '0;
        end else if ({1'b0, ld_c_q} == n - CntW'(1)) begin
          ld_c_q <= '0; ld_r_q <= ld_r_q + IdxW'(1);
        end else ld_c_q <= ld_c_q + IdxW'(1);
      end
      case (state_q)
        has_pkg::StRowMinRd: begin
          if (i_q == '0 && j_q == '0) begin
            row_has_q <= '0; col_has_q <= '0;
          end
        end
        has_pkg::StGreedyChk: begin
          if (rdata == '0 && !col_has_q[j_q]) begin
            row_has_q[i_q] <= 1'b1; col_has_q[j_q] <= 1'b1;
          end
        end
        has_pkg::StAugInit: begin
          row_reach_q <= {{(MaxSize-1){1'b0}}, 1'b1} << i_q;
          col_reach_q <= '0;
        end
        has_pkg::StAugChk: begin
          if (aug_hit) begin
            col_reach_q[j_q] <= 1'b1;
            if (col_has_q[j_q] && {1'b0, d_q} + CntW'(1) < CntW'(MaxSize)) begin
              row_reach_q[col_match_q[j_q]] <= 1'b1;
            end
          end
          k_q <= '0;
        end
        has_pkg::StAugWrite: begin
          row_has_q[stk_row_q[k_q]] <= 1'b1;
          col_has_q[stk_col_q[k_q]] <= 1'b1;
          k_q <= k_q + IdxW'(1);
        end
        default: ;
      endcase
    end
  end

  // Payload registers: matches, stack, column minima, accumulator.
  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    case (state_q)
      has_pkg::StRowSubWr: begin
        if (i_q == '0 || sub_y < colmin_q[j_q]) colmin_q[j_q] <= sub_y;
      end
      has_pkg::StGreedyChk: begin
        if (rdata == '0 && !col_has_q[j_q]) begin
          row_match_q[i_q] <= j_q; col_match_q[j_q] <= i_q;
        end
      end
      has_pkg::StAugInit: begin
        stk_row_q[0] <= i_q; stk_next_q[0] <= '0;
      end
      has_pkg::StAugRd: ;
      has_pkg::StAugChk: begin
        if (aug_hit) begin
          stk_next_q[d_q] <= {1'b0, j_q} + CntW'(1);
          stk_col_q[d_q] <= j_q;
          if (col_has_q[j_q] && {1'b0, d_q} + CntW'(1) < CntW'(MaxSize)) begin
            stk_row_q[d_q + IdxW'(1)] <= col_match_q[j_q];
            stk_next_q[d_q + IdxW'(1)] <= '0;
          end
        end else begin
          stk_next_q[d_q] <= {1'b0, j_q} + CntW'(1);
        end
      end
      has_pkg::StAugWrite: begin
        row_match_q[stk_row_q[k_q]] <= stk_col_q[k_q];
        col_match_q[stk_col_q[k_q]] <= stk_row_q[k_q];
      end
      default: ;
    endcase
  end

  // Output strobe: one row per cycle in the emit state.
  always_comb begin
    result_valid_o = (state_q == has_pkg::StEmit);
    row_index_o = 4'(i_q);
    assigned_column_o = ok_q ? 4'(row_match_q[i_q]) : 4'(i_q);
    failed_o = !ok_q;
    last_o = i_end;
  end

`ifndef ASSERT_OFF
  a_no_result_while_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == has_pkg::StIdle) |-> !result_valid_o) else $error("result while idle");
  a_last_ends_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && last_o) |=> (state_q == has_pkg::StIdle)) else $error("emit overrun");
  a_matched_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != has_pkg::StIdle) |-> (matched_q <= n)) else $error("match count overflow");
`endif

endmodule

// ----- dv/hungarian_assignment_solver_test.sv -----
module hungarian_assignment_solver_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MaxSize   = has_pkg::MaxSize;
  localparam int unsigned CycleCap  = 20000000;
  localparam int unsigned SettleGap = 40;

  // One row assignment as the block reports it.
  typedef struct packed {
    logic [3:0] row;
    logic [3:0] column;
    logic       failed;
    logic       last;
  } assignment_t;

  // One cost element waiting to go out, with the sender's idle odds.
  typedef struct {
    logic [31:0] cost;
    int unsigned gap_pct;
  } cost_item_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_q = 1'b0;
  logic [31:0] cost_q = '0;
  logic        cfg_valid_q = 1'b0;
  logic [0:0]  cfg_index_q = has_pkg::RegMatrixSize;
  logic [15:0] cfg_data_q = '0;
  logic        busy;
  logic        cfg_ready;
  logic        result_valid;
  logic [3:0]  row_index;
  logic [3:0]  assigned_column;
  logic        failed;
  logic        last;

  always #4 clk_i = ~clk_i;

  hungarian_assignment_solver u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start_q),
    .cost_i           (cost_q),
    .busy             (busy),
    .cfg_valid_i      (cfg_valid_q),
    .cfg_ready_o      (cfg_ready),
    .cfg_index_i      (cfg_index_q),
    .cfg_data_i       (cfg_data_q),
    .result_valid_o   (result_valid),
    .row_index_o      (row_index),
    .assigned_column_o(assigned_column),
    .failed_o         (failed),
    .last_o           (last)
  );

  // ---------------------------------------------------------------------------
  // Solver shadow: the predictor keeps its own copy of the registers, the
  // loaded matrix and the matching bookkeeping, all at the block's widths.
  // ---------------------------------------------------------------------------
  logic [4:0]       size_reg;
  logic [15:0]      rounds_reg;
  logic [has_pkg::CostW-1:0] cost_mat [MaxSize*MaxSize];
  logic [3:0]       row_mate [MaxSize];
  bit               row_owned [MaxSize];
  logic [3:0]       col_mate [MaxSize];
  bit               col_owned [MaxSize];
  bit               row_hit [MaxSize];
  bit               col_hit [MaxSize];
  int unsigned      fill_count;

  assignment_t pending_assignments[$];
  cost_item_t  cost_backlog[$];

  int unsigned mismatches;
  int unsigned items_sent;
  int unsigned rows_checked;
  int unsigned failed_solves;
  int unsigned solves;
  int unsigned cycles;

  function automatic int unsigned active_size();
    if (size_reg == 0) return 1;
    if (size_reg > MaxSize) return MaxSize;
    return size_reg;
  endfunction

  function automatic logic [has_pkg::CostW-1:0] cell_at(int unsigned i, int unsigned j);
    return cost_mat[i*MaxSize + j];
  endfunction

  // Depth-first search for an augmenting path from an unmatched row; columns
  // are tried in ascending order and the path is flipped on success.
  function automatic bit grow_matching(int unsigned root, int unsigned n);
    int unsigned stk_row [MaxSize];
    int unsigned stk_col [MaxSize];
    int unsigned stk_next [MaxSize];
    int unsigned depth;
    int unsigned r;
    int unsigned j;
    bit          found;
    for (int k = 0; k < MaxSize; k++) begin
      row_hit[k] = 1'b0;
      col_hit[k] = 1'b0;
    end
    depth = 0;
    stk_row[0] = root;
    stk_next[0] = 0;
    row_hit[root] = 1'b1;
    forever begin
      r = stk_row[depth];
      found = 1'b0;
      for (j = stk_next[depth]; j < n; j++) begin
        if (cell_at(r, j) == 0 && !(col_owned[j] && col_mate[j] == r) && !col_hit[j]) begin
          found = 1'b1;
          break;
        end
      end
      if (!found) begin
        if (depth == 0) return 1'b0;
        depth--;
        continue;
      end
      stk_next[depth] = j + 1;
      stk_col[depth] = j;
      col_hit[j] = 1'b1;
      if (!col_owned[j]) begin
        for (int k = 0; k <= depth; k++) begin
          row_mate[stk_row[k]] = 4'(stk_col[k]);
          row_owned[stk_row[k]] = 1'b1;
          col_mate[stk_col[k]] = 4'(stk_row[k]);
          col_owned[stk_col[k]] = 1'b1;
        end
        return 1'b1;
      end
      if (depth + 1 >= MaxSize) continue;
      depth++;
      stk_row[depth] = col_mate[j];
      stk_next[depth] = 0;
      row_hit[stk_row[depth]] = 1'b1;
    end
  endfunction

  // Rounds of reduce, greedy match, augment and adjust; 1 on a perfect match.
  function automatic bit solve_assignment(int unsigned n);
    logic [has_pkg::CostW-1:0] col_min [MaxSize];
    logic [has_pkg::CostW-1:0] row_min;
    logic [has_pkg::CostW-1:0] low;
    logic [has_pkg::CostW-1:0] v;
    int unsigned      matched;
    bit               progress;
    for (int unsigned rnd = 0; rnd < rounds_reg; rnd++) begin
      for (int k = 0; k < MaxSize; k++) begin
        row_owned[k] = 1'b0;
        col_owned[k] = 1'b0;
      end
      matched = 0;
      for (int j = 0; j < n; j++) col_min[j] = has_pkg::CostTop;
      for (int i = 0; i < n; i++) begin
        row_min = has_pkg::CostTop;
        for (int j = 0; j < n; j++) if (cell_at(i, j) < row_min) row_min = cell_at(i, j);
        for (int j = 0; j < n; j++) begin
          cost_mat[i*MaxSize + j] = cell_at(i, j) - row_min;
          if (cell_at(i, j) < col_min[j]) col_min[j] = cell_at(i, j);
        end
      end
      for (int i = 0; i < n; i++)
        for (int j = 0; j < n; j++) cost_mat[i*MaxSize + j] = cell_at(i, j) - col_min[j];
      for (int i = 0; i < n; i++) begin
        for (int j = 0; j < n; j++) begin
          if (cell_at(i, j) == 0 && !col_owned[j]) begin
            row_mate[i] = 4'(j);
            row_owned[i] = 1'b1;
            col_mate[j] = 4'(i);
            col_owned[j] = 1'b1;
            matched++;
            break;
          end
        end
      end
      if (matched == n) return 1'b1;
      do begin
        progress = 1'b0;
        for (int i = 0; i < n; i++) begin
          if (!row_owned[i] && grow_matching(i, n)) begin
            progress = 1'b1;
            matched++;
            if (matched == n) return 1'b1;
          end
        end
      end while (progress);
      // Shift the smallest uncovered value from the last search tree.
      low = has_pkg::CostTop;
      for (int i = 0; i < n; i++)
        for (int j = 0; j < n; j++)
          if (row_hit[i] && !col_hit[j] && cell_at(i, j) < low) low = cell_at(i, j);
      for (int i = 0; i < n; i++) begin
        for (int j = 0; j < n; j++) begin
          v = cell_at(i, j);
          if (row_hit[i] && !col_hit[j]) v = v - low;
          if (!row_hit[i] && col_hit[j])
            v = (v > has_pkg::CostTop - low) ? has_pkg::CostTop : v + low;
          cost_mat[i*MaxSize + j] = v;
        end
      end
    end
    for (int i = 0; i < n; i++) begin
      row_mate[i] = 4'(i);
      row_owned[i] = 1'b1;
    end
    return 1'b0;
  endfunction

  // Store one element; the element that completes the matrix queues n rows.
  function automatic void load_cost(logic [31:0] cost);
    int unsigned n;
    bit          ok;
    assignment_t a;
    n = active_size();
    if (fill_count >= n*n) fill_count = 0;
    cost_mat[(fill_count / n)*MaxSize + (fill_count % n)] = {16'h0, cost};
    fill_count++;
    if (fill_count < n*n) return;
    fill_count = 0;
    ok = solve_assignment(n);
    solves++;
    if (!ok) failed_solves++;
    for (int i = 0; i < n; i++) begin
      a.row = 4'(i);
      a.column = row_mate[i];
      a.failed = !ok;
      a.last = (i == n - 1);
      pending_assignments = {pending_assignments, a};
    end
  endfunction

  function automatic void apply_register(logic [0:0] idx, logic [15:0] data);
    if (idx == has_pkg::RegMatrixSize) begin
      size_reg = data[4:0];
      fill_count = 0;
    end else begin
      rounds_reg = data;
    end
  endfunction

  initial begin
    size_reg = 5'd16;
    rounds_reg = 16'd100;
    fill_count = 0;
    for (int k = 0; k < MaxSize*MaxSize; k++) cost_mat[k] = '0;
    for (int k = 0; k < MaxSize; k++) begin
      row_mate[k] = '0;
      col_mate[k] = '0;
      row_owned[k] = 1'b0;
      col_owned[k] = 1'b0;
      row_hit[k] = 1'b0;
      col_hit[k] = 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Cost driver: take a transaction when start and not busy, then either hold
  // the current element or advance to the next one from the backlog.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= 1'b0;
    end else begin
      if (start_q && !busy) begin
        load_cost(cost_q);
        items_sent++;
      end
      if (!start_q || !busy) begin
        if (cost_backlog.size() != 0 &&
            $urandom_range(99, 0) >= cost_backlog[0].gap_pct) begin
          start_q <= 1'b1;
          cost_q <= cost_backlog[0].cost;
          void'(cost_backlog.pop_front());
        end else begin
          start_q <= 1'b0;
        end
      end
    end
  end

  // Result monitor: every strobe must match the oldest expected row.
  always @(posedge clk_i) begin
    if (rst_ni && result_valid) begin
      assignment_t want;
      if (pending_assignments.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: row %0d column %0d failed %0b last %0b",
                   row_index, assigned_column, failed, last);
      end else begin
        want = pending_assignments.pop_front();
        rows_checked++;
        if (want.row != row_index || want.column != assigned_column ||
            want.failed != failed || want.last != last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: row %0d/%0d column %0d/%0d failed %0b/%0b last %0b/%0b %s",
                     want.row, row_index, want.column, assigned_column,
                     want.failed, failed, want.last, last, "(expected/actual)");
        end
      end
    end
  end

  // Watchdog: give up on a hung solver.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleCap) begin
      $display("timeout after %0d cycles", cycles);
      $display("hungarian_assignment_solver_test: errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencing helpers
  // ---------------------------------------------------------------------------

  // Wait until every element went out and every row came back, then let the
  // block settle in case a partial load is still being absorbed.
  task automatic drain();
    while (cost_backlog.size() != 0 || start_q || pending_assignments.size() != 0)
      @(posedge clk_i);
    repeat (SettleGap) @(posedge clk_i);
  endtask

  task automatic write_register(logic [0:0] idx, logic [15:0] data);
    drain();
    cfg_valid_q <= 1'b1;
    cfg_index_q <= idx;
    cfg_data_q  <= data;
    do @(posedge clk_i); while (!(cfg_valid_q && cfg_ready));
    apply_register(idx, data);
    cfg_valid_q <= 1'b0;
  endtask

  task automatic push_cost(logic [31:0] cost, int unsigned gap_pct);
    cost_item_t it;
    it.cost = cost;
    it.gap_pct = gap_pct;
    cost_backlog = {cost_backlog, it};
  endtask

  // Queue one n-by-n matrix; flavor picks narrow (lots of ties), wide, or
  // extreme values.
  task automatic push_matrix(int unsigned n, int unsigned flavor, int unsigned gap_pct);
    logic [31:0] c;
    for (int k = 0; k < n*n; k++) begin
      case (flavor)
        0: c = $urandom_range(7, 0);
        1: c = $urandom;
        default: begin
          case ($urandom_range(3, 0))
            0: c = 32'h0;
            1: c = 32'hFFFF_FFFF;
            2: c = $urandom_range(3, 0);
            default: c = $urandom;
          endcase
        end
      endcase
      push_cost(c, gap_pct);
    end
  endtask

  initial begin
    int unsigned gap;
    int unsigned n;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: single element at both extremes, size zero acting as one.
    write_register(has_pkg::RegMatrixSize, 16'd1);
    push_cost(32'hFFFF_FFFF, 0);
    write_register(has_pkg::RegMatrixSize, 16'd0);
    push_cost(32'h0, 0);

    // Two by two with zeros on the diagonal, then zero rounds forcing the identity fallback.
    write_register(has_pkg::RegMatrixSize, 16'd2);
    write_register(has_pkg::RegMaxRounds, 16'd100);
    push_cost(32'h0, 0);
    push_cost(32'hFFFF_FFFF, 0);
    push_cost(32'hFFFF_FFFF, 0);
    push_cost(32'h0, 0);
    write_register(has_pkg::RegMaxRounds, 16'd0);
    push_matrix(2, 1, 0);

    // Partial load dropped by a size write; upper data bits are ignored.
    write_register(has_pkg::RegMaxRounds, 16'd1);
    push_cost(32'h5, 0);
    push_cost(32'h7, 0);
    push_cost(32'h9, 0);
    write_register(has_pkg::RegMatrixSize, 16'hFFE3);
    push_matrix(3, 0, 0);

    // Random: mostly small matrices, the sender's idle odds shift by phase.
    while (items_sent + cost_backlog.size() + start_q < 100) begin
      drain();
      if (items_sent < 50) gap = 35;
      else if (items_sent < 80) gap = 72;
      else gap = 0;
      n = ($urandom_range(9, 0) == 0) ? 1 : $urandom_range(5, 2);
      if ($urandom_range(2, 0) == 0) write_register(has_pkg::RegMatrixSize, 16'(n));
      else if (active_size() <= 5) n = active_size();
      else write_register(has_pkg::RegMatrixSize, 16'(n));
      case ($urandom_range(4, 0))
        0: write_register(has_pkg::RegMaxRounds, 16'd1);
        1: write_register(has_pkg::RegMaxRounds, 16'($urandom_range(3, 2)));
        2: write_register(has_pkg::RegMaxRounds, 16'd100);
        default: ;
      endcase
      push_matrix(active_size(), $urandom_range(2, 0), gap);
    end

    // Largest rounds limit on a tiny matrix, then one larger matrix with
    // extreme values.
    write_register(has_pkg::RegMatrixSize, 16'd2);
    write_register(has_pkg::RegMaxRounds, 16'hFFFF);
    push_matrix(2, 0, 0);
    write_register(has_pkg::RegMaxRounds, 16'd100);
    write_register(has_pkg::RegMatrixSize, 16'd6);
    push_matrix(6, 2, 0);
    drain();

    $display("covered %0d cost elements, %0d solves (%0d hit the round limit)",
             items_sent, solves, failed_solves);
    $display("checked %0d row assignments, %0d mismatches", rows_checked, mismatches);
    if (mismatches == 0 && pending_assignments.size() == 0) begin
      $display("hungarian_assignment_solver_test: clean");
    end else begin
      $display("hungarian_assignment_solver_test: errors");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/has_pkg.sv
hdl/has_ram.sv
hdl/hungarian_assignment_solver.sv
dv/hungarian_assignment_solver_test.sv
